### sv/adsr_pkg.sv
// Shared types, codes and constants for the ADSR envelope oscillator.
`timescale 1ns / 1ps
package adsr_pkg;

  localparam int MUL_W     = 32;
  localparam int MUL_DIG   = 4;
  localparam int MUL_STEPS = MUL_W / MUL_DIG;
  localparam int LVL_W     = 16;
  localparam int DUR_W     = 24;
  localparam int NUM_W     = LVL_W + DUR_W;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_ATTACK  = 3'd1;
  localparam logic [2:0] ST_DECAY   = 3'd2;
  localparam logic [2:0] ST_HOLD    = 3'd3;
  localparam logic [2:0] ST_RELEASE = 3'd4;

  localparam logic [1:0] WM_SINE   = 2'd0;
  localparam logic [1:0] WM_SQUARE = 2'd1;
  localparam logic [1:0] WM_SAW    = 2'd2;

  localparam logic [2:0] REG_WAVE    = 3'd0;
  localparam logic [2:0] REG_PEAK    = 3'd1;
  localparam logic [2:0] REG_SUSTAIN = 3'd2;
  localparam logic [2:0] REG_ATTACK  = 3'd3;
  localparam logic [2:0] REG_DECAY   = 3'd4;
  localparam logic [2:0] REG_HOLD    = 3'd5;
  localparam logic [2:0] REG_RELEASE = 3'd6;

  localparam logic [LVL_W-1:0] LVL_ONE  = 16'h8000;
  localparam logic [LVL_W-1:0] LVL_HALF = 16'h4000;

  // Q30 odd polynomial coefficients of the quarter sine
  localparam logic [30:0] SIN_C1 = 31'd1686629713;
  localparam logic [30:0] SIN_C3 = 31'd693598667;
  localparam logic [30:0] SIN_C5 = 31'd85569306;
  localparam logic [30:0] SIN_C7 = 31'd5026993;
  localparam logic [30:0] SIN_C9 = 31'd172272;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DUR_W-1:0] den;
  } div_req_t;

  // coefficient subtracted at Horner step 1..4
  function automatic logic [30:0] sin_coef(input logic [2:0] step);
    logic [30:0] c;
    case (step)
      3'd1:    c = SIN_C7;
      3'd2:    c = SIN_C5;
      3'd3:    c = SIN_C3;
      default: c = SIN_C1;
    endcase
    return c;
  endfunction

endpackage

### sv/adsr_mul.sv
// Digit-serial unsigned multiplier, four multiplier bits per cycle.
`timescale 1ns / 1ps
module adsr_mul import adsr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  mul_req_t           req,
  output logic               done,
  output logic [2*MUL_W-1:0] prod
);

  localparam int PW    = MUL_W + MUL_DIG;
  localparam int CNT_W = $clog2(MUL_STEPS);

  logic [MUL_W-1:0]   a_r, b_r, b_nxt;
  logic [2*MUL_W-1:0] p_r, p_nxt;
  logic [PW-1:0]      part;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r, done_r;

  // add one partial product to the upper half, shift the product right a digit
  assign part  = PW'(p_r[2*MUL_W-1:MUL_W]) + PW'(a_r) * PW'(b_r[MUL_DIG-1:0]);
  assign p_nxt = {part, p_r[MUL_W-1:MUL_DIG]};
  assign b_nxt = b_r >> MUL_DIG;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        a_r    <= req.a;
        b_r    <= req.b;
        p_r    <= '0;
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        p_r   <= p_nxt;
        b_r   <= b_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MUL_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = p_r;

endmodule

### sv/adsr_div.sv
// Bit-serial restoring divider for envelope ramp levels, one quotient bit per cycle.
`timescale 1ns / 1ps
module adsr_div import adsr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic             done,
  output logic [LVL_W-1:0] quo
);

  localparam int CNT_W = $clog2(LVL_W);

  logic [DUR_W-1:0] rem_r, rem_nxt, den_r;
  logic [LVL_W-1:0] num_r, q_r;
  logic [DUR_W:0]   trial;
  logic [DUR_W+1:0] diff;
  logic             ge;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;

  assign trial   = {rem_r, num_r[LVL_W-1]};
  assign diff    = {1'b0, trial} - {2'b00, den_r};
  assign ge      = !diff[DUR_W+1];
  assign rem_nxt = ge ? diff[DUR_W-1:0] : trial[DUR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        // quotient fits LVL_W bits, so the upper dividend bits are below the divisor
        rem_r  <= req.num[NUM_W-1:LVL_W];
        num_r  <= req.num[LVL_W-1:0];
        den_r  <= req.den;
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        num_r <= num_r << 1;
        q_r   <= {q_r[LVL_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(LVL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

### sv/adsr_envelope_oscillator_unit.sv
// Top level: ADSR envelope sequencer driving a polynomial sine / square / saw oscillator.
//
//  channel  direction  handshake           payload
//  in       input      in_valid/in_stall   in_start_req, in_freq_step, in_note_length
//  out      output     out_valid/out_stall out_sample, out_stage, out_note_done, out_error
//  cfg      input      cfg_we              cfg_index, cfg_data
//
// One beat at a time. A sine or square beat with a ramp takes 8 multiplies on the
// 4-bit serial multiplier and one divide on the bit-serial divider.
// Hold or saw beats skip the divide or the sine steps; idle and error beats skip both.
// Reset is synchronous; it loads register defaults and clears the note state.
// A stalled result stays in the output register; the next beat is taken meanwhile.
`timescale 1ns / 1ps
module adsr_envelope_oscillator_unit import adsr_pkg::*; #(
  parameter int SAMPLE_BITS     = 24,
  parameter int SINE_TABLE_BITS = 10,
  parameter int TIME_BITS       = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_start_req,
  input  logic [30:0]                   in_freq_step,
  input  logic [DUR_W-1:0]              in_note_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic [2:0]                    out_stage,
  output logic                          out_note_done,
  output logic                          out_error,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [DUR_W-1:0]              cfg_data
);

  localparam int CW  = ((TIME_BITS > DUR_W) ? TIME_BITS : DUR_W) + 2;
  localparam int XSH = 32 - SINE_TABLE_BITS;
  localparam logic [CW-1:0] TMAX = {{(CW - TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}};
  localparam logic [31:0]   SMAX = 32'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic [30:0]   ONE30 = 31'h4000_0000;

  typedef enum logic [2:0] {
    S_IDLE, S_LMUL, S_LDIV, S_WAVE, S_SMUL, S_SCL0, S_SCALE, S_OUT
  } state_t;

  // configuration
  logic [1:0]       wave_r;
  logic [LVL_W-1:0] peak_r, sus_r;
  logic [DUR_W-1:0] att_r, dec_r, hold_r, rel_r;

  // note state
  logic [31:0]          phase_r;
  logic [TIME_BITS-1:0] count_r, len_r, seg_r;
  logic [2:0]           stage_r;
  logic [LVL_W-1:0]     cur_r;
  logic [30:0]          step_r;

  // per-beat work registers
  state_t           state_r;
  logic [31:0]      wphase_r;
  logic [DUR_W-1:0] den_r;
  logic [2:0]       wst_r, sstep_r;
  logic             wdone_r, werr_r, wact_r, neg_r;
  logic [LVL_W-1:0] lvl_r, mag_r;
  logic [30:0]      x_r, x2_r;
  logic signed [SAMPLE_BITS-1:0] samp_r;
  mul_req_t         mul_req_r;
  div_req_t         div_req_r;

  logic                          out_valid_r, out_done_r, out_err_r;
  logic [2:0]                    out_stage_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;

  logic               mul_done, div_done;
  logic [2*MUL_W-1:0] mul_prod;
  logic [LVL_W-1:0]   div_quo;

  adsr_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req_r), .done(mul_done), .prod(mul_prod));
  adsr_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req_r), .done(div_done), .quo(div_quo));

  // ---- envelope decision for the beat being accepted ----
  logic                 err_c, act_c, rel_done_c, need_div_c;
  logic [CW-1:0]        sum_c, nl_c, rel_c, kc_c;
  logic [TIME_BITS-1:0] len0_c, t_c, seg_c, len_c, k_c;
  logic [2:0]           st_c;
  logic [LVL_W-1:0]     cur_c, nlv_c;
  logic [DUR_W-1:0]     fac_c, den_c;
  logic [31:0]          phase0_c;
  logic [30:0]          stepv_c;
  logic                 leave_c;

  always_comb begin
    err_c  = (peak_r > LVL_ONE) || (sus_r > peak_r);
    sum_c  = CW'(att_r) + CW'(dec_r) + CW'(hold_r);
    nl_c   = (in_note_length != '0) ? CW'(in_note_length) : ((sum_c > TMAX) ? TMAX : sum_c);
    len0_c = nl_c[TIME_BITS-1:0];

    st_c     = in_start_req ? ST_ATTACK : stage_r;
    t_c      = in_start_req ? '0 : count_r;
    seg_c    = in_start_req ? '0 : seg_r;
    len_c    = in_start_req ? len0_c : len_r;
    cur_c    = in_start_req ? '0 : cur_r;
    phase0_c = in_start_req ? '0 : phase_r;
    stepv_c  = in_start_req ? in_freq_step : step_r;
    act_c    = (st_c == ST_ATTACK) || (st_c == ST_DECAY) || (st_c == ST_HOLD) ||
               (st_c == ST_RELEASE);

    // zero release with zero sustain borrows the decay time
    rel_c = ((rel_r == '0) && (sus_r == '0)) ? CW'(dec_r) : CW'(rel_r);

    if (st_c == ST_ATTACK) begin
      if (t_c >= len_c) begin
        st_c  = ST_RELEASE;
        seg_c = t_c;
      end else if (CW'(t_c - seg_c) >= CW'(att_r)) begin
        st_c  = ST_DECAY;
        seg_c = t_c;
        cur_c = peak_r;
      end
    end
    if (st_c == ST_DECAY) begin
      if (t_c >= len_c) begin
        st_c  = ST_RELEASE;
        seg_c = t_c;
      end else if (CW'(t_c - seg_c) >= CW'(dec_r)) begin
        st_c  = ST_HOLD;
        seg_c = t_c;
        cur_c = sus_r;
      end
    end
    leave_c = (hold_r != '0) ? ((CW'(t_c - seg_c) >= CW'(hold_r)) || (t_c >= len_c))
                             : ((CW'(t_c) + rel_c) >= CW'(len_c));
    if ((st_c == ST_HOLD) && leave_c) begin
      st_c  = ST_RELEASE;
      seg_c = t_c;
    end

    k_c        = t_c - seg_c;
    kc_c       = CW'(k_c) + 1'b1;
    rel_done_c = (rel_c == '0) || (kc_c >= rel_c);

    // ramp operands: level = nlv * fac / den (decay subtracts from peak)
    case (st_c)
      ST_ATTACK: begin
        fac_c = kc_c[DUR_W-1:0];
        nlv_c = peak_r;
        den_c = att_r;
      end
      ST_DECAY: begin
        fac_c = kc_c[DUR_W-1:0];
        nlv_c = peak_r - sus_r;
        den_c = dec_r;
      end
      default: begin
        fac_c = DUR_W'(rel_c - kc_c);
        nlv_c = cur_c;
        den_c = rel_c[DUR_W-1:0];
      end
    endcase
    need_div_c = (st_c == ST_ATTACK) || (st_c == ST_DECAY) ||
                 ((st_c == ST_RELEASE) && !rel_done_c);
  end

  // ---- oscillator helpers ----
  logic [SINE_TABLE_BITS-1:0] idx_c;
  logic [29:0]                xbase_c;
  logic [30:0]                x_c, p_c;
  logic [32:0]                rnd_c;
  logic [LVL_W-1:0]           smag_c;
  logic [31:0]                v_c, sat_c;
  logic [SAMPLE_BITS-1:0]     vs_c;

  always_comb begin
    idx_c   = wphase_r[31:XSH];
    xbase_c = {idx_c[SINE_TABLE_BITS-3:0], {XSH{1'b0}}};
    x_c     = idx_c[SINE_TABLE_BITS-2] ? (ONE30 - {1'b0, xbase_c}) : {1'b0, xbase_c};
    p_c     = sin_coef(sstep_r) - mul_prod[60:30];
    rnd_c   = {1'b0, mul_prod[61:30]} + 33'd16384;
    smag_c  = (rnd_c[32:15] > 18'(LVL_ONE)) ? LVL_ONE : rnd_c[30:15];
    v_c     = {mul_prod[30:0], 1'b0} >> (32 - SAMPLE_BITS);
    sat_c   = (v_c > SMAX) ? SMAX : v_c;
    vs_c    = sat_c[SAMPLE_BITS-1:0];
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r      <= WM_SQUARE;
      peak_r      <= 16'd16384;
      sus_r       <= 16'd8192;
      att_r       <= 24'd441;
      dec_r       <= 24'd30870;
      hold_r      <= '0;
      rel_r       <= '0;
      phase_r     <= '0;
      count_r     <= '0;
      len_r       <= '0;
      seg_r       <= '0;
      stage_r     <= ST_IDLE;
      cur_r       <= '0;
      step_r      <= '0;
      state_r     <= S_IDLE;
      mul_req_r   <= '0;
      div_req_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mul_req_r.start <= 1'b0;
      div_req_r.start <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          REG_WAVE:    wave_r <= cfg_data[1:0];
          REG_PEAK:    peak_r <= cfg_data[LVL_W-1:0];
          REG_SUSTAIN: sus_r  <= cfg_data[LVL_W-1:0];
          REG_ATTACK:  att_r  <= cfg_data;
          REG_DECAY:   dec_r  <= cfg_data;
          REG_HOLD:    hold_r <= cfg_data;
          REG_RELEASE: rel_r  <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            werr_r  <= err_c;
            wdone_r <= 1'b0;
            wact_r  <= 1'b0;
            wst_r   <= ST_IDLE;
            samp_r  <= '0;
            state_r <= S_OUT;
            if (err_c || !act_c) begin
              stage_r <= ST_IDLE;
            end else begin
              if (in_start_req) begin
                step_r <= in_freq_step;
                len_r  <= len0_c;
              end
              stage_r  <= st_c;
              seg_r    <= seg_c;
              cur_r    <= cur_c;
              wphase_r <= phase0_c;
              phase_r  <= phase0_c + {1'b0, stepv_c};
              count_r  <= (t_c == '1) ? t_c : t_c + 1'b1;
              wact_r   <= 1'b1;
              wst_r    <= st_c;
              wdone_r  <= (st_c == ST_RELEASE) && rel_done_c;
              den_r    <= den_c;
              if (need_div_c) begin
                mul_req_r <= '{start: 1'b1, a: MUL_W'(fac_c), b: MUL_W'(nlv_c)};
                state_r   <= S_LMUL;
              end else begin
                lvl_r   <= (st_c == ST_HOLD) ? sus_r : '0;
                state_r <= S_WAVE;
              end
            end
          end
        end
        S_LMUL: begin
          if (mul_done) begin
            div_req_r <= '{start: 1'b1, num: mul_prod[NUM_W-1:0], den: den_r};
            state_r   <= S_LDIV;
          end
        end
        S_LDIV: begin
          if (div_done) begin
            lvl_r   <= (wst_r == ST_DECAY) ? (peak_r - div_quo) : div_quo;
            state_r <= S_WAVE;
          end
        end
        S_WAVE: begin
          case (wave_r)
            WM_SINE, WM_SQUARE: begin
              x_r       <= x_c;
              neg_r     <= idx_c[SINE_TABLE_BITS-1];
              sstep_r   <= '0;
              mul_req_r <= '{start: 1'b1, a: MUL_W'(x_c), b: MUL_W'(x_c)};
              state_r   <= S_SMUL;
            end
            WM_SAW: begin
              mag_r   <= {1'b0, wphase_r[31:17]};
              neg_r   <= 1'b0;
              state_r <= S_SCL0;
            end
            default: begin
              mag_r   <= '0;
              neg_r   <= 1'b0;
              state_r <= S_SCL0;
            end
          endcase
        end
        S_SMUL: begin
          // Horner evaluation: x^2, then four coefficient steps, then times x
          if (mul_done) begin
            sstep_r <= sstep_r + 1'b1;
            case (sstep_r)
              3'd0: begin
                x2_r      <= mul_prod[60:30];
                mul_req_r <= '{start: 1'b1, a: MUL_W'(mul_prod[60:30]), b: MUL_W'(SIN_C9)};
              end
              3'd1, 3'd2, 3'd3: begin
                mul_req_r <= '{start: 1'b1, a: MUL_W'(x2_r), b: MUL_W'(p_c)};
              end
              3'd4: begin
                mul_req_r <= '{start: 1'b1, a: MUL_W'(x_r), b: MUL_W'(p_c)};
              end
              default: begin
                if (wave_r == WM_SQUARE) mag_r <= (smag_c >= LVL_HALF) ? LVL_ONE : '0;
                else mag_r <= smag_c;
                state_r <= S_SCL0;
              end
            endcase
          end
        end
        S_SCL0: begin
          mul_req_r <= '{start: 1'b1, a: MUL_W'(lvl_r), b: MUL_W'(mag_r)};
          state_r   <= S_SCALE;
        end
        S_SCALE: begin
          if (mul_done) begin
            samp_r  <= neg_r ? -$signed(vs_c) : $signed(vs_c);
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_sample_r <= samp_r;
            out_stage_r  <= wst_r;
            out_done_r   <= wdone_r;
            out_err_r    <= werr_r;
            if (wact_r) begin
              if (wst_r != ST_RELEASE) cur_r <= lvl_r;
              if (wdone_r) stage_r <= ST_IDLE;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sample    = out_sample_r;
  assign out_stage     = out_stage_r;
  assign out_note_done = out_done_r;
  assign out_error     = out_err_r;

endmodule

### sv/adsr_chk.sv
// Port-level checker for the ADSR envelope oscillator, bound to the top level.
`timescale 1ns / 1ps
module adsr_chk import adsr_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          in_start_req,
  input logic [30:0]                   in_freq_step,
  input logic [DUR_W-1:0]              in_note_length,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] out_sample,
  input logic [2:0]                    out_stage,
  input logic                          out_note_done,
  input logic                          out_error,
  input logic                          cfg_we,
  input logic [2:0]                    cfg_index,
  input logic [DUR_W-1:0]              cfg_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_sample == '0 && out_stage == ST_IDLE && !out_note_done)
    else $error("error beat not silent");

  a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_note_done |-> out_stage == ST_RELEASE && !out_error)
    else $error("note_done outside release");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous beat in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample) && $stable(out_stage))
    else $error("stalled result changed");

endmodule

bind adsr_envelope_oscillator_unit adsr_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_adsr_chk (.*);
